/* sv/hhdt_pkg.sv */
// Package for the heading hold drive and turn sequencer: word types, codes and constants.
package hhdt_pkg;

    // Angles are in 1/16 degree, so one revolution is 5760 counts
    localparam logic [12:0] FULL_TURN   = 13'd5760;
    localparam logic [12:0] HALF_TURN   = 13'd2880;
    localparam logic [13:0] DUTY_MAX    = 14'd14999;
    localparam logic [13:0] RIGHT_OFFS  = 14'd100;

    // Input modes
    localparam logic [1:0] MODE_DRIVE  = 2'd0;
    localparam logic [1:0] MODE_TURN   = 2'd1;
    localparam logic [1:0] MODE_SAMPLE = 2'd2;
    localparam logic [1:0] MODE_TICK   = 2'd3;

    // Motor actions
    localparam logic [1:0] ACT_STOP    = 2'd0;
    localparam logic [1:0] ACT_FWD     = 2'd1;
    localparam logic [1:0] ACT_LEFT    = 2'd2;
    localparam logic [1:0] ACT_RIGHT   = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_STEER_GAIN    = 3'd0;
    localparam logic [2:0] CFG_DISTANCE_TRIM = 3'd1;
    localparam logic [2:0] CFG_TURN_TRIM     = 3'd2;
    localparam logic [2:0] CFG_NUDGE_MS      = 3'd3;
    localparam logic [2:0] CFG_NUDGE_DUTY    = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef struct packed {
        logic [1:0]  mode;
        logic [13:0] speed;
        logic [15:0] target;
        logic [12:0] heading;
        logic [31:0] odometer;
    } item_t;

    typedef struct packed {
        logic [1:0]  motor_action;
        logic [13:0] left_duty;
        logic [13:0] right_duty;
        logic        busy_res;
        logic        finished;
    } result_t;

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_DRIVE  = 6'b000010,
        PH_DNUDGE = 6'b000100,
        PH_SPIN_R = 6'b001000,
        PH_SPIN_L = 6'b010000,
        PH_TNUDGE = 6'b100000
    } phase_t;

endpackage

/* sv/heading_hold_drive_and_turn_sequencer_core.sv */
// Heading hold drive and turn sequencer: input register, sequencing logic and result register.
//
// The block returns exactly one result word for each word it takes, in order. A word passes
// an input register, then one pass of sequencing logic (heading relative to the start
// heading, one 16x11 steering multiply, goal compares, phase update) into the result
// register, sustaining one word per clock while result_ready stays high; the state registers
// (phase, start references, duties, nudge timer) update in the same cycle a word leaves the
// input register, so the next word always sees the effect of the previous one.
// A result waiting in the result register does not stop the input register from filling: the
// input side stalls only when both registers hold words and result_ready is low.
// Drive starts run forward until the odometer has advanced by ceil((target - distance_trim)
// * 22.5) steps, bending the right duty by steer_gain (Q8.8) per degree of drift on each
// sensor sample; turn starts spin right up to 180 degrees, left above. Both end with timed
// nudges of nudge_ms millisecond ticks at nudge_duty until the heading is level (drive) or
// within half a degree of the goal (turn), then report finished. Angles are in 1/16 degree.
// Configuration is taken at any time (cfg_ready is always high) but must only be written
// while the block is idle.
module heading_hold_drive_and_turn_sequencer_core
    import hhdt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  item_t                  item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_t                result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers
    logic [15:0] steer_gain_reg;
    logic [7:0]  distance_trim_reg;
    logic [10:0] turn_trim_reg;
    logic [9:0]  nudge_ms_reg;
    logic [13:0] nudge_duty_reg;

    // Pipeline registers
    logic    s1_valid_reg;
    item_t   s1_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;

    // Sequencer state
    phase_t      phase_reg,          phase_next;
    logic [12:0] start_heading_reg,  start_heading_next;
    logic [31:0] start_odometer_reg, start_odometer_next;
    logic [20:0] step_goal_reg,      step_goal_next;
    logic [12:0] angle_goal_reg,     angle_goal_next;
    logic [13:0] drive_left_reg,     drive_left_next;
    logic [13:0] drive_right_reg,    drive_right_next;
    logic [9:0]  nudge_left_ms_reg,  nudge_left_ms_next;
    logic        nudge_dir_reg,      nudge_dir_next;
    logic [12:0] last_heading_reg,   last_heading_next;

    logic    advance;
    item_t   in_norm;
    result_t res;

    // Handshake: the input register moves on whenever the result register is free or emptying
    assign advance      = s1_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready   = !s1_valid_reg || advance;
    assign result_valid = out_valid_reg;
    assign result       = out_res_reg;
    assign cfg_ready    = 1'b1;

    // Fold heading into one revolution and clip speed on the way in
    always_comb
    begin
        in_norm = item;
        if (item.heading >= FULL_TURN)
        begin
            in_norm.heading = item.heading - FULL_TURN;
        end
        if (item.speed > DUTY_MAX)
        begin
            in_norm.speed = DUTY_MAX;
        end
    end

    // ---------------------------------------------------------------------
    // Datapath shared by the branches below
    // ---------------------------------------------------------------------
    logic [12:0] rel_src;
    logic [12:0] rel;
    logic [12:0] neg_rel;
    logic        steer_pos;
    logic        steer_neg;
    logic [10:0] mag;
    logic [26:0] prod;
    logic [27:0] ceil_sum;
    logic [15:0] inc;
    logic signed [17:0] r_acc;
    logic [13:0] r_sat;
    logic [31:0] odo_diff;
    logic        drive_running;
    logic signed [13:0] turn_err;
    logic        drv_lvl_go, drv_lvl_dir;
    logic        trn_lvl_go, trn_lvl_dir;
    logic [15:0] trip_len;
    logic [21:0] dist_x45;
    logic [20:0] goal_new;
    logic [13:0] right_base;
    logic [13:0] rel_trim;
    logic [13:0] rel_left;
    logic [13:0] goal_trim;
    logic [13:0] nudge_duty_sat;

    // Ticks re-evaluate the last recorded heading, samples use the new one
    assign rel_src = (s1_item_reg.mode == MODE_TICK) ? last_heading_reg : s1_item_reg.heading;
    assign rel     = (rel_src >= start_heading_reg) ? (rel_src - start_heading_reg)
                                                    : (rel_src + FULL_TURN - start_heading_reg);
    assign neg_rel = FULL_TURN - rel;

    // Steering: one multiplier serves both drift directions
    assign steer_pos = (rel > 13'd16) && (rel < 13'd1440);
    assign steer_neg = (rel > 13'd4320) && (rel < 13'd5744);
    assign mag       = steer_pos ? rel[10:0] : neg_rel[10:0];
    assign prod      = 27'(steer_gain_reg * mag);
    assign ceil_sum  = {1'b0, prod} + 28'd4095;

    always_comb
    begin
        inc   = 16'd0;
        r_acc = $signed({4'b0000, drive_right_reg});
        if (steer_pos)
        begin
            inc   = {1'b0, prod[26:12]};
            r_acc = r_acc + $signed({2'b00, inc});
        end
        else if (steer_neg)
        begin
            inc   = ceil_sum[27:12];
            r_acc = r_acc - $signed({2'b00, inc});
        end
    end

    always_comb
    begin
        if (r_acc < 0)
        begin
            r_sat = 14'd0;
        end
        else if (r_acc > $signed({4'b0000, DUTY_MAX}))
        begin
            r_sat = DUTY_MAX;
        end
        else
        begin
            r_sat = r_acc[13:0];
        end
    end

    assign odo_diff      = s1_item_reg.odometer - start_odometer_reg;
    assign drive_running = (odo_diff[31:21] == 11'd0) && (odo_diff[20:0] < step_goal_reg);

    // Levelling decisions: go means start a nudge, dir 0 left, 1 right
    assign drv_lvl_go  = ((rel > 13'd8) && (rel < 13'd480)) || ((rel > 13'd5280) && (rel < 13'd5752));
    assign drv_lvl_dir = !((rel > 13'd8) && (rel < 13'd480));
    assign turn_err    = $signed({1'b0, rel}) - $signed({1'b0, angle_goal_reg});
    assign trn_lvl_go  = (turn_err > 14'sd8) || (turn_err < -14'sd8);
    assign trn_lvl_dir = (turn_err < -14'sd8);

    // Spin stop compares
    assign rel_trim  = {1'b0, rel} + {3'b000, turn_trim_reg};
    assign rel_left  = (rel == 13'd0) ? {1'b0, FULL_TURN} : {1'b0, rel};
    assign goal_trim = {1'b0, angle_goal_reg} + {3'b000, turn_trim_reg};

    // Start values: distance goal is ceil(d * 22.5) = (45d + 1) / 2
    assign trip_len   = (s1_item_reg.target > {8'd0, distance_trim_reg})
                        ? (s1_item_reg.target - {8'd0, distance_trim_reg}) : 16'd0;
    assign dist_x45   = ({6'd0, trip_len} << 5) + ({6'd0, trip_len} << 3)
                        + ({6'd0, trip_len} << 2) + {6'd0, trip_len};
    assign goal_new   = 21'((23'(dist_x45) + 23'd1) >> 1);
    assign right_base = (s1_item_reg.speed >= RIGHT_OFFS) ? (s1_item_reg.speed - RIGHT_OFFS)
                                                          : 14'd0;

    assign nudge_duty_sat = (nudge_duty_reg > DUTY_MAX) ? DUTY_MAX : nudge_duty_reg;

    // ---------------------------------------------------------------------
    // Sequencing
    // ---------------------------------------------------------------------
    logic nz_go;
    logic nz_dir;
    logic nz_turn;
    logic fin;

    always_comb
    begin
        phase_next          = phase_reg;
        start_heading_next  = start_heading_reg;
        start_odometer_next = start_odometer_reg;
        step_goal_next      = step_goal_reg;
        angle_goal_next     = angle_goal_reg;
        drive_left_next     = drive_left_reg;
        drive_right_next    = drive_right_reg;
        nudge_left_ms_next  = nudge_left_ms_reg;
        nudge_dir_next      = nudge_dir_reg;
        last_heading_next   = last_heading_reg;
        res                 = '0;
        nz_go               = 1'b0;
        nz_dir              = 1'b0;
        nz_turn             = 1'b0;
        fin                 = 1'b0;

        case (s1_item_reg.mode)
            MODE_TICK:
            begin
                case (phase_reg)
                    PH_DNUDGE, PH_TNUDGE:
                    begin
                        if (nudge_left_ms_reg > 10'd1)
                        begin
                            nudge_left_ms_next = nudge_left_ms_reg - 10'd1;
                            res = '{motor_action: {1'b1, nudge_dir_reg},
                                    left_duty: nudge_duty_sat, right_duty: nudge_duty_sat,
                                    busy_res: 1'b1, finished: 1'b0};
                        end
                        else
                        begin
                            // Last tick of a nudge: look at the heading again
                            nudge_left_ms_next = 10'd0;
                            nz_turn = (phase_reg == PH_TNUDGE);
                            if (phase_reg == PH_TNUDGE)
                            begin
                                nz_go  = trn_lvl_go;
                                nz_dir = trn_lvl_dir;
                            end
                            else
                            begin
                                nz_go  = drv_lvl_go;
                                nz_dir = drv_lvl_dir;
                            end
                            fin = !nz_go;
                        end
                    end
                    PH_DRIVE:
                    begin
                        res = '{ACT_FWD, drive_left_reg, drive_right_reg, 1'b1, 1'b0};
                    end
                    PH_SPIN_R:
                    begin
                        res = '{ACT_RIGHT, drive_left_reg, drive_right_reg, 1'b1, 1'b0};
                    end
                    PH_SPIN_L:
                    begin
                        res = '{ACT_LEFT, drive_left_reg, drive_right_reg, 1'b1, 1'b0};
                    end
                    default:
                    begin
                        res = '0;
                    end
                endcase
            end

            MODE_SAMPLE:
            begin
                last_heading_next = s1_item_reg.heading;
                case (phase_reg)
                    PH_DRIVE:
                    begin
                        if (drive_running)
                        begin
                            drive_right_next = r_sat;
                            res = '{ACT_FWD, drive_left_reg, r_sat, 1'b1, 1'b0};
                        end
                        else
                        begin
                            nz_go  = drv_lvl_go;
                            nz_dir = drv_lvl_dir;
                            fin    = !drv_lvl_go;
                        end
                    end
                    PH_SPIN_R:
                    begin
                        if (rel_trim < {1'b0, angle_goal_reg})
                        begin
                            res = '{ACT_RIGHT, drive_left_reg, drive_right_reg, 1'b1, 1'b0};
                        end
                        else
                        begin
                            nz_turn = 1'b1;
                            nz_go   = trn_lvl_go;
                            nz_dir  = trn_lvl_dir;
                            fin     = !trn_lvl_go;
                        end
                    end
                    PH_SPIN_L:
                    begin
                        if (rel_left > goal_trim)
                        begin
                            res = '{ACT_LEFT, drive_left_reg, drive_right_reg, 1'b1, 1'b0};
                        end
                        else
                        begin
                            nz_turn = 1'b1;
                            nz_go   = trn_lvl_go;
                            nz_dir  = trn_lvl_dir;
                            fin     = !trn_lvl_go;
                        end
                    end
                    PH_DNUDGE, PH_TNUDGE:
                    begin
                        res = '{motor_action: {1'b1, nudge_dir_reg},
                                left_duty: nudge_duty_sat, right_duty: nudge_duty_sat,
                                busy_res: 1'b1, finished: 1'b0};
                    end
                    default:
                    begin
                        res = '0;
                    end
                endcase
            end

            default:
            begin
                // Drive or turn start: take new references; relative heading is zero here
                last_heading_next   = s1_item_reg.heading;
                start_heading_next  = s1_item_reg.heading;
                start_odometer_next = s1_item_reg.odometer;
                drive_left_next     = s1_item_reg.speed;
                drive_right_next    = right_base;
                nudge_left_ms_next  = 10'd0;
                if (s1_item_reg.mode == MODE_DRIVE)
                begin
                    step_goal_next = goal_new;
                    phase_next     = PH_DRIVE;
                    if (goal_new != 21'd0)
                    begin
                        res = '{ACT_FWD, s1_item_reg.speed, right_base, 1'b1, 1'b0};
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
                else if ((s1_item_reg.target == 16'd0) ||
                         (s1_item_reg.target >= {3'b000, FULL_TURN}))
                begin
                    fin = 1'b1;
                end
                else
                begin
                    angle_goal_next = s1_item_reg.target[12:0];
                    nz_turn         = 1'b1;
                    if (s1_item_reg.target <= {3'b000, HALF_TURN})
                    begin
                        if ({5'd0, turn_trim_reg} < s1_item_reg.target)
                        begin
                            phase_next = PH_SPIN_R;
                            res = '{ACT_RIGHT, s1_item_reg.speed, right_base, 1'b1, 1'b0};
                        end
                        else
                        begin
                            // Error is minus the goal: nudge right unless within half a degree
                            nz_go  = (s1_item_reg.target > 16'd8);
                            nz_dir = 1'b1;
                            fin    = !nz_go;
                        end
                    end
                    else
                    begin
                        if ({3'b000, FULL_TURN} > (s1_item_reg.target + {5'd0, turn_trim_reg}))
                        begin
                            phase_next = PH_SPIN_L;
                            res = '{ACT_LEFT, s1_item_reg.speed, right_base, 1'b1, 1'b0};
                        end
                        else
                        begin
                            nz_go  = 1'b1;
                            nz_dir = 1'b1;
                        end
                    end
                end
            end
        endcase

        // Start a nudge or close the sequence
        if (nz_go)
        begin
            phase_next         = nz_turn ? PH_TNUDGE : PH_DNUDGE;
            nudge_dir_next     = nz_dir;
            nudge_left_ms_next = nudge_ms_reg;
            res = '{motor_action: {1'b1, nz_dir},
                    left_duty: nudge_duty_sat, right_duty: nudge_duty_sat,
                    busy_res: 1'b1, finished: 1'b0};
        end
        else if (fin)
        begin
            phase_next = PH_IDLE;
            res        = '{ACT_STOP, 14'd0, 14'd0, 1'b0, 1'b1};
        end
    end

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steer_gain_reg    <= 16'd256;
            distance_trim_reg <= 8'd0;
            turn_trim_reg     <= 11'd0;
            nudge_ms_reg      <= 10'd40;
            nudge_duty_reg    <= 14'd5000;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_STEER_GAIN:    steer_gain_reg    <= cfg_data;
                CFG_DISTANCE_TRIM: distance_trim_reg <= cfg_data[7:0];
                CFG_TURN_TRIM:     turn_trim_reg     <= cfg_data[10:0];
                CFG_NUDGE_MS:      nudge_ms_reg      <= cfg_data[9:0];
                CFG_NUDGE_DUTY:    nudge_duty_reg    <= cfg_data[13:0];
                default:           steer_gain_reg    <= steer_gain_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                s1_valid_reg <= item_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            s1_item_reg <= in_norm;
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            start_heading_reg  <= '0;
            start_odometer_reg <= '0;
            step_goal_reg      <= '0;
            angle_goal_reg     <= '0;
            drive_left_reg     <= '0;
            drive_right_reg    <= '0;
            nudge_left_ms_reg  <= '0;
            nudge_dir_reg      <= 1'b0;
            last_heading_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg          <= phase_next;
            start_heading_reg  <= start_heading_next;
            start_odometer_reg <= start_odometer_next;
            step_goal_reg      <= step_goal_next;
            angle_goal_reg     <= angle_goal_next;
            drive_left_reg     <= drive_left_next;
            drive_right_reg    <= drive_right_next;
            nudge_left_ms_reg  <= nudge_left_ms_next;
            nudge_dir_reg      <= nudge_dir_next;
            last_heading_reg   <= last_heading_next;
        end
    end

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (result_valid && (result.busy_res == (phase_reg != PH_IDLE))))
        else $error("busy flag disagrees with the sequencer phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.finished) |-> (!result.busy_res && result.motor_action == ACT_STOP))
        else $error("finished word is not a stop");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.motor_action == ACT_STOP)
            |-> (result.left_duty == 14'd0 && result.right_duty == 14'd0))
        else $error("stop word carries a duty");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.left_duty <= DUTY_MAX && result.right_duty <= DUTY_MAX))
        else $error("duty above range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_DNUDGE && phase_reg != PH_TNUDGE) |-> (drive_right_reg <= DUTY_MAX))
        else $error("stored right duty above range");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the heading hold drive and turn sequencer core.
module tb;
    import hhdt_pkg::*;

    // Clock, reset and the three channels of the block
    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   item_valid   = 1'b0;
    logic                   item_ready;
    item_t                  item         = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    result_t                result;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    heading_hold_drive_and_turn_sequencer_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Words waiting to be driven, and motor words the sequencer owes us
    item_t       pending_words[$];
    result_t     expected_moves[$];
    result_t     next_move;
    int unsigned words_queued   = 0;
    int unsigned words_accepted = 0;
    int unsigned mismatch_count = 0;
    int          gap_left       = 0;
    int          stall_left     = 0;
    logic        calm_tail      = 1'b0;

    // What the stimulus generator assumes about the current register setting
    int plan_odo_trim   = 0;
    int plan_spin_trim  = 0;
    int plan_nudge_len  = 40;

    // Register copies as they were written through the cfg channel (reset values)
    logic [15:0] gain_q88  = 16'd256;
    logic [7:0]  odo_trim  = 8'd0;
    logic [10:0] spin_trim = 11'd0;
    logic [9:0]  nudge_len = 10'd40;
    logic [13:0] nudge_pwm = 14'd5000;

    // Sequencer state of the predictor (reset values)
    phase_t      seq_phase        = PH_IDLE;
    logic [12:0] hold_heading     = '0;
    logic [12:0] heading_now      = '0;
    logic [12:0] angle_target     = '0;
    logic [31:0] odo_origin       = '0;
    logic [20:0] step_target      = '0;
    logic [13:0] left_cmd         = '0;
    logic [13:0] right_cmd        = '0;
    logic [9:0]  nudge_ticks_left = '0;
    logic        nudge_to_right   = 1'b0;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    function automatic logic [13:0] clamp_duty(longint v);
        if (v < 0)
            return 14'd0;
        if (v > longint'(int'(DUTY_MAX)))
            return DUTY_MAX;
        return 14'(v);
    endfunction

    // Heading relative to the start heading, 0..5759
    function automatic int rel_heading(logic [12:0] h);
        if (h >= hold_heading)
            return int'(h) - int'(hold_heading);
        return int'(h) + int'(FULL_TURN) - int'(hold_heading);
    endfunction

    function automatic result_t motor_word(logic [1:0] act, logic [13:0] l, logic [13:0] r,
                                           logic busy, logic fin);
        result_t w;
        w.motor_action = act;
        w.left_duty    = l;
        w.right_duty   = r;
        w.busy_res     = busy;
        w.finished     = fin;
        return w;
    endfunction

    function automatic result_t finish_word();
        seq_phase = PH_IDLE;
        return motor_word(ACT_STOP, 14'd0, 14'd0, 1'b0, 1'b1);
    endfunction

    function automatic result_t nudge_word();
        logic [13:0] d;
        d = clamp_duty(longint'(nudge_pwm));
        return motor_word(nudge_to_right ? ACT_RIGHT : ACT_LEFT, d, d, 1'b1, 1'b0);
    endfunction

    function automatic result_t begin_nudge(phase_t ph, logic to_right);
        seq_phase        = ph;
        nudge_to_right   = to_right;
        nudge_ticks_left = nudge_len;
        return nudge_word();
    endfunction

    // After a drive: nudge back toward the start heading, or finish when level
    function automatic result_t level_drive(int rel);
        if (rel > 8 && rel < 480)
            return begin_nudge(PH_DNUDGE, 1'b0);
        if (rel > 5280 && rel < 5752)
            return begin_nudge(PH_DNUDGE, 1'b1);
        return finish_word();
    endfunction

    // After a spin: nudge until within half a degree of the goal angle
    function automatic result_t level_turn(int rel);
        int err;
        err = rel - int'(angle_target);
        if (err > 8)
            return begin_nudge(PH_TNUDGE, 1'b0);
        if (err < -8)
            return begin_nudge(PH_TNUDGE, 1'b1);
        return finish_word();
    endfunction

    function automatic result_t evaluate_sample(logic [31:0] odo);
        int          rel;
        int          unwrapped;
        longint      r;
        logic [31:0] travelled;
        rel       = rel_heading(heading_now);
        travelled = odo - odo_origin;
        case (seq_phase)
            PH_DRIVE: begin
                if (travelled < {11'd0, step_target}) begin
                    // steer: drift right speeds up the right wheel, drift left slows it
                    r = longint'(right_cmd);
                    if (rel > 16 && rel < 1440)
                        r += (longint'(gain_q88) * rel) >> 12;
                    else if (rel > 4320 && rel < 5744)
                        r -= (longint'(gain_q88) * (5760 - rel) + 4095) >> 12;
                    right_cmd = clamp_duty(r);
                    return motor_word(ACT_FWD, left_cmd, right_cmd, 1'b1, 1'b0);
                end
                return level_drive(rel);
            end
            PH_SPIN_R: begin
                if (rel < int'(angle_target) - int'(spin_trim))
                    return motor_word(ACT_RIGHT, left_cmd, right_cmd, 1'b1, 1'b0);
                return level_turn(rel);
            end
            PH_SPIN_L: begin
                // a left spin still sitting on its start heading has a full turn to go
                unwrapped = (rel == 0) ? int'(FULL_TURN) : rel;
                if (unwrapped > int'(angle_target) + int'(spin_trim))
                    return motor_word(ACT_LEFT, left_cmd, right_cmd, 1'b1, 1'b0);
                return level_turn(rel);
            end
            PH_DNUDGE, PH_TNUDGE:
                return nudge_word();
            default:
                return motor_word(ACT_STOP, 14'd0, 14'd0, 1'b0, 1'b0);
        endcase
    endfunction

    function automatic result_t evaluate_tick();
        case (seq_phase)
            PH_DNUDGE, PH_TNUDGE: begin
                if (nudge_ticks_left > 1) begin
                    nudge_ticks_left--;
                    return nudge_word();
                end
                // nudge over: look at the newest heading, possibly nudging again
                nudge_ticks_left = '0;
                if (seq_phase == PH_DNUDGE)
                    return level_drive(rel_heading(heading_now));
                return level_turn(rel_heading(heading_now));
            end
            PH_DRIVE:  return motor_word(ACT_FWD, left_cmd, right_cmd, 1'b1, 1'b0);
            PH_SPIN_R: return motor_word(ACT_RIGHT, left_cmd, right_cmd, 1'b1, 1'b0);
            PH_SPIN_L: return motor_word(ACT_LEFT, left_cmd, right_cmd, 1'b1, 1'b0);
            default:   return motor_word(ACT_STOP, 14'd0, 14'd0, 1'b0, 1'b0);
        endcase
    endfunction

    // One accepted word in, the motor word it causes out
    function automatic result_t sequencer_step(item_t w);
        logic [13:0] spd;
        int          trip_len;
        if (w.mode == MODE_TICK)
            return evaluate_tick();
        heading_now = (w.heading >= FULL_TURN) ? w.heading - FULL_TURN : w.heading;
        if (w.mode == MODE_SAMPLE)
            return evaluate_sample(w.odometer);
        // drive or turn start: take new references, abort whatever was running
        spd              = clamp_duty(longint'(w.speed));
        hold_heading     = heading_now;
        odo_origin       = w.odometer;
        left_cmd         = spd;
        right_cmd        = (spd >= RIGHT_OFFS) ? spd - RIGHT_OFFS : 14'd0;
        nudge_ticks_left = '0;
        if (w.mode == MODE_DRIVE) begin
            trip_len = int'(w.target) - int'(odo_trim);
            if (trip_len < 0)
                trip_len = 0;
            // 22.5 steps per unit of distance, rounded up
            step_target = 21'((trip_len * 45 + 1) >> 1);
            seq_phase   = PH_DRIVE;
        end
        else begin
            if (w.target == 16'd0 || w.target >= FULL_TURN)
                return finish_word();
            angle_target = w.target[12:0];
            seq_phase    = (w.target <= HALF_TURN) ? PH_SPIN_R : PH_SPIN_L;
        end
        return evaluate_sample(w.odometer);
    endfunction

    // ---------------------------------------------------------------
    // Driver: queued words in order, random gaps between words
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            item_valid <= 1'b0;
            item       <= '0;
            gap_left   <= 0;
        end
        else begin
            if (item_valid && item_ready) begin
                expected_moves.push_back(sequencer_step(item));
                words_accepted++;
            end
            if (item_valid && !item_ready) begin
                // hold the word until it is taken
            end
            else if (gap_left > 0) begin
                gap_left   <= gap_left - 1;
                item_valid <= 1'b0;
            end
            else if (!calm_tail && pending_words.size() > 0 && $urandom_range(0, 11) == 0) begin
                gap_left   <= $urandom_range(0, 17);
                item_valid <= 1'b0;
            end
            else if (pending_words.size() > 0) begin
                item       <= pending_words.pop_front();
                item_valid <= 1'b1;
            end
            else begin
                item_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: compare each motor word, stall in random bursts
    // ---------------------------------------------------------------
    task automatic check_field(string name, logic [13:0] want, logic [13:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            result_ready <= 1'b0;
            stall_left   <= 0;
        end
        else begin
            if (result_valid && result_ready) begin
                if (expected_moves.size() == 0) begin
                    $error("motor word %h arrived with nothing expected", result);
                    mismatch_count++;
                end
                else begin
                    next_move = expected_moves.pop_front();
                    check_field("motor_action", next_move.motor_action, result.motor_action);
                    check_field("left_duty", next_move.left_duty, result.left_duty);
                    check_field("right_duty", next_move.right_duty, result.right_duty);
                    check_field("busy_res", next_move.busy_res, result.busy_res);
                    check_field("finished", next_move.finished, result.finished);
                end
            end
            if (stall_left > 0) begin
                stall_left   <= stall_left - 1;
                result_ready <= 1'b0;
            end
            else if (!calm_tail && $urandom_range(0, 13) == 0) begin
                stall_left   <= $urandom_range(0, 17);
                result_ready <= 1'b0;
            end
            else begin
                result_ready <= 1'b1;
            end
        end
    end

    // Track register writes at the handshake
    always @(posedge clk) begin
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_STEER_GAIN:    gain_q88  <= cfg_data[15:0];
                CFG_DISTANCE_TRIM: odo_trim  <= cfg_data[7:0];
                CFG_TURN_TRIM:     spin_trim <= cfg_data[10:0];
                CFG_NUDGE_MS:      nudge_len <= cfg_data[9:0];
                CFG_NUDGE_DUTY:    nudge_pwm <= cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    task automatic push_word(logic [1:0] mode, int speed, int target, int heading,
                             logic [31:0] odo);
        item_t w;
        w.mode     = mode;
        w.speed    = 14'(speed);
        w.target   = 16'(target);
        w.heading  = 13'(heading);
        w.odometer = odo;
        pending_words.push_back(w);
        words_queued++;
    endtask

    function automatic int at_rel(int base, int rel);
        return (base + rel + 3 * 5760) % 5760;
    endfunction

    function automatic int pick_speed();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 150);
        return $urandom_range(0, 14999);
    endfunction

    task automatic push_tick();
        push_word(MODE_TICK, $urandom_range(0, 16383), $urandom_range(0, 65535),
                  $urandom_range(0, 8191), $urandom);
    endtask

    // Tick up to the length of the running nudge, then level the heading near centre and wait
    // it out; a long nudge is cut short by the next start
    task automatic queue_nudge_tail(int h0, int centre);
        int k;
        k = $urandom_range(0, (plan_nudge_len > 64) ? 20 : plan_nudge_len);
        repeat (k) push_tick();
        push_word(MODE_SAMPLE, pick_speed(), $urandom_range(0, 65535),
                  at_rel(h0, centre + int'($urandom_range(0, 16)) - 8), $urandom);
        repeat ((plan_nudge_len > 64) ? 16 : plan_nudge_len + 2) push_tick();
    endtask

    task automatic queue_drive();
        int          h0;
        int          trip_len;
        int          goal;
        int          n;
        int          target;
        logic [31:0] odo0;
        h0   = $urandom_range(0, 5759);
        odo0 = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 600) : $urandom;
        case ($urandom_range(0, 9))
            0: begin
                // the trim swallows the whole distance
                target   = $urandom_range(0, plan_odo_trim);
                trip_len = 0;
            end
            1: begin
                target   = 65535;
                trip_len = 65535 - plan_odo_trim;
            end
            default: begin
                trip_len = $urandom_range(1, 24);
                target   = plan_odo_trim + trip_len;
            end
        endcase
        goal = (trip_len * 45 + 1) / 2;
        push_word(MODE_DRIVE, pick_speed(), target, h0, odo0);
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            push_word(MODE_SAMPLE, pick_speed(), $urandom_range(0, 65535),
                      at_rel(h0, int'($urandom_range(0, 3200)) - 1600),
                      odo0 + 32'(goal * i / n));
            if ($urandom_range(0, 3) == 0)
                push_tick();
        end
        // cross the goal with some drift left over
        push_word(MODE_SAMPLE, pick_speed(), $urandom_range(0, 65535),
                  at_rel(h0, int'($urandom_range(0, 1200)) - 600),
                  odo0 + 32'(goal) + $urandom_range(0, 40));
        queue_nudge_tail(h0, 0);
    endtask

    task automatic queue_turn();
        int h0;
        int ang;
        int n;
        int rel;
        h0 = $urandom_range(0, 5759);
        case ($urandom_range(0, 11))
            0:       ang = 2880;
            1:       ang = 2881;
            2:       ang = $urandom_range(1, 16);
            3:       ang = $urandom_range(5740, 5759);
            4:       ang = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(5760, 65535);
            5, 6, 7: ang = $urandom_range(1, 2880);
            default: ang = $urandom_range(2881, 5759);
        endcase
        push_word(MODE_TURN, pick_speed(), ang, h0, $urandom);
        n = $urandom_range(1, 5);
        for (int i = 1; i <= n; i++) begin
            if (ang <= 2880)
                rel = ang * i / (n + 1);
            else if (i == 1 && $urandom_range(0, 1) == 0)
                rel = 0;
            else
                rel = 5760 - (5760 - ang) * i / (n + 1);
            push_word(MODE_SAMPLE, pick_speed(), $urandom_range(0, 65535), at_rel(h0, rel),
                      $urandom);
            if ($urandom_range(0, 3) == 0)
                push_tick();
        end
        // arrive somewhere around the goal, inside or outside the trim band
        push_word(MODE_SAMPLE, pick_speed(), $urandom_range(0, 65535),
                  at_rel(h0, ang + int'($urandom_range(0, 2 * plan_spin_trim + 60))
                             - plan_spin_trim - 30), $urandom);
        queue_nudge_tail(h0, ang);
    endtask

    task automatic queue_noise();
        repeat ($urandom_range(1, 6))
            push_word(2'($urandom_range(0, 3)), $urandom_range(0, 16383),
                      $urandom_range(0, 65535), $urandom_range(0, 8191), $urandom);
    endtask

    task automatic queue_random_traffic(int budget);
        int unsigned stop_at;
        stop_at = words_queued + budget;
        while (words_queued < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: queue_drive();
                4, 5, 6, 7: queue_turn();
                default:    queue_noise();
            endcase
        end
        // a zero-angle turn leaves the sequencer idle for the next register write
        push_word(MODE_TURN, 0, 0, 0, 32'd0);
    endtask

    // Wait until every word is taken and every motor word checked, then let it settle
    task automatic wait_drained();
        do
            @(posedge clk);
        while (words_accepted != words_queued || expected_moves.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_regs(int gain, int dtrim, int ttrim, int nms, int nduty);
        logic [CFG_INDEX_W-1:0] idx  [5];
        logic [CFG_DATA_W-1:0]  vals [5];
        idx[0]  = CFG_STEER_GAIN;
        idx[1]  = CFG_DISTANCE_TRIM;
        idx[2]  = CFG_TURN_TRIM;
        idx[3]  = CFG_NUDGE_MS;
        idx[4]  = CFG_NUDGE_DUTY;
        vals[0] = 16'(gain);
        vals[1] = 16'(dtrim);
        vals[2] = 16'(ttrim);
        vals[3] = 16'(nms);
        vals[4] = 16'(nduty);
        plan_odo_trim  = dtrim;
        plan_spin_trim = ttrim;
        plan_nudge_len = nms;
        @(posedge clk);
        // keep valid high across back-to-back writes, drop it after the last one
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words at the reset register values
        push_word(MODE_TICK, 0, 0, 0, 32'd0);                       // tick while idle
        push_word(MODE_SAMPLE, 16383, 65535, 8191, 32'hFFFF_FFFF);  // sample while idle
        push_word(MODE_TURN, 3000, 0, 100, 32'd0);                  // zero angle
        push_word(MODE_TURN, 3000, 5760, 100, 32'd0);               // full turn
        push_word(MODE_TURN, 3000, 65535, 5759, 32'd0);
        push_word(MODE_DRIVE, 16383, 0, 8000, 32'd0);               // zero distance
        push_word(MODE_DRIVE, 50, 1, 200, 32'hFFFF_FFF0);           // right base floors
        push_word(MODE_SAMPLE, 0, 0, 140, 32'h0000_0000);           // drift left, odo wraps
        push_word(MODE_SAMPLE, 0, 0, 600, 32'h0000_0004);           // drift right
        push_word(MODE_TICK, 0, 0, 0, 32'd0);                       // repeat forward
        push_word(MODE_SAMPLE, 0, 0, 300, 32'h0000_0008);           // goal reached, nudge
        push_word(MODE_SAMPLE, 0, 0, 5700, 32'h0000_0009);          // only recorded
        push_word(MODE_DRIVE, 14999, 65535, 0, 32'd0);              // abort the nudge
        push_word(MODE_SAMPLE, 0, 0, 1439, 32'd100);
        push_word(MODE_TURN, 0, 0, 0, 32'd0);
        wait_drained();

        program_regs(65535, 0, 0, 2, 14999);
        push_word(MODE_DRIVE, 14999, 2, 1000, 32'd0);
        push_word(MODE_SAMPLE, 0, 0, 2439, 32'd10);                 // steer saturates high
        push_word(MODE_SAMPLE, 0, 0, 1200, 32'd50);                 // nudge left
        push_word(MODE_TICK, 0, 0, 0, 32'd0);
        push_word(MODE_TICK, 0, 0, 0, 32'd0);                       // next nudge, same word
        push_word(MODE_SAMPLE, 0, 0, 740, 32'd0);
        push_word(MODE_TICK, 0, 0, 0, 32'd0);
        push_word(MODE_TICK, 0, 0, 0, 32'd0);                       // flip to nudge right
        push_word(MODE_SAMPLE, 0, 0, 1003, 32'd0);
        push_word(MODE_TICK, 0, 0, 0, 32'd0);
        push_word(MODE_TICK, 0, 0, 0, 32'd0);                       // level, finished
        push_word(MODE_TURN, 8000, 2880, 0, 32'd0);                 // half turn spins right
        push_word(MODE_SAMPLE, 0, 0, 2890, 32'd0);
        push_word(MODE_TURN, 14999, 2881, 100, 32'd0);              // left spin from rel 0
        push_word(MODE_SAMPLE, 0, 0, 2975, 32'd0);
        wait_drained();

        // Random traffic across register settings, extremes first
        program_regs(0, 255, 1439, 1, 0);
        queue_random_traffic(80);
        wait_drained();

        program_regs(65535, 0, 0, 3, 14999);
        queue_random_traffic(80);
        wait_drained();

        program_regs($urandom_range(1, 1024), $urandom_range(0, 40), $urandom_range(0, 120),
                     $urandom_range(1, 8), $urandom_range(0, 14999));
        queue_random_traffic(80);
        wait_drained();

        // Longest nudge: keep it to a single turn and drive
        program_regs($urandom_range(0, 65535), $urandom_range(0, 255), $urandom_range(0, 1439),
                     1023, $urandom_range(0, 14999));
        queue_turn();
        queue_drive();
        push_word(MODE_TURN, 0, 0, 0, 32'd0);
        wait_drained();

        // Last stretch runs without gaps or stalls
        calm_tail = 1'b1;
        program_regs($urandom_range(0, 65535), $urandom_range(0, 60), $urandom_range(0, 300),
                     $urandom_range(1, 6), $urandom_range(0, 14999));
        queue_random_traffic(80);
        wait_drained();

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Hang guard
    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
